// ===== src/dmn_pkg.sv =====
// ----------------------------------------------------------------------------
// dmn_pkg
// Shared types, codes and helpers of the distributed mutex node.
// ----------------------------------------------------------------------------
package dmn_pkg;

    // widths fixed by the message format
    localparam int CLK_W      = 32;
    localparam int ID_W       = 3;
    localparam int CNT_W      = 4;   // holds a group size up to 8 and counters up to 15
    localparam int RESULT_CAP = 8;

    // stream packing
    localparam int IN_DATA_W  = 40;  // msg_source, msg_clock
    localparam int IN_USER_W  = 4;   // kind, msg_type
    localparam int OUT_DATA_W = 40;  // send_dest, send_clock, flags
    localparam int OUT_USER_W = 2;   // send_type

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

    // input kind codes
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;
    localparam logic [1:0] KIND_MESSAGE = 2'd3;

    // message type codes, shared by incoming and outgoing traffic
    localparam logic [1:0] MSG_REQUEST = 2'd0;
    localparam logic [1:0] MSG_REPLY   = 2'd1;
    localparam logic [1:0] MSG_FINISH  = 2'd2;
    localparam logic [1:0] MSG_NONE    = 2'd3;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOCAL_REQ,
        OP_LOCAL_REL,
        OP_LOCAL_FIN,
        OP_MSG_REQ,
        OP_MSG_REP,
        OP_MSG_FIN
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  src;
        logic [CLK_W-1:0] mclk;
    } t_cmd;

    function automatic logic [CLK_W-1:0] sat_inc(input logic [CLK_W-1:0] x);
        return (x == {CLK_W{1'b1}}) ? x : x + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc4(input logic [CNT_W-1:0] x);
        return (x == {CNT_W{1'b1}}) ? x : x + 1'b1;
    endfunction

endpackage

// ===== src/dmn_front.sv =====
// ----------------------------------------------------------------------------
// dmn_front
// Accepts input transactions and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module dmn_front (
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dmn_pkg::IN_DATA_W-1:0]  i_s_tdata,  // [2:0] msg_source, [34:3] msg_clock
    input  logic [dmn_pkg::IN_USER_W-1:0]  i_s_tuser,  // [1:0] kind, [3:2] msg_type
    input  logic [dmn_pkg::ID_W-1:0]       i_node_id,
    input  logic [dmn_pkg::CNT_W-1:0]      i_group,
    input  logic                           i_q_full,
    output logic                           o_push,
    output dmn_pkg::t_cmd                  o_cmd
);
    import dmn_pkg::*;

    logic [1:0]       w_kind;
    logic [1:0]       w_mtype;
    logic [ID_W-1:0]  w_src;
    logic             w_valid_msg;

    assign w_kind  = i_s_tuser[1:0];
    assign w_mtype = i_s_tuser[3:2];
    assign w_src   = i_s_tdata[ID_W-1:0];

    // messages from ourselves, from outside the group or of unknown type are dropped
    assign w_valid_msg = (w_mtype != MSG_NONE) && (w_src != i_node_id)
                       && ({1'b0, w_src} < i_group);

    always_comb begin
        o_cmd.src  = w_src;
        o_cmd.mclk = i_s_tdata[ID_W +: CLK_W];
        unique case (w_kind)
            KIND_REQUEST: o_cmd.op = OP_LOCAL_REQ;
            KIND_RELEASE: o_cmd.op = OP_LOCAL_REL;
            KIND_FINISH:  o_cmd.op = OP_LOCAL_FIN;
            KIND_MESSAGE: begin
                if (!w_valid_msg) begin
                    o_cmd.op = OP_NOP;
                end else if (w_mtype == MSG_REQUEST) begin
                    o_cmd.op = OP_MSG_REQ;
                end else if (w_mtype == MSG_REPLY) begin
                    o_cmd.op = OP_MSG_REP;
                end else begin
                    o_cmd.op = OP_MSG_FIN;
                end
            end
            default: o_cmd.op = OP_NOP;
        endcase
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

endmodule

// ===== src/dmn_queue.sv =====
// ----------------------------------------------------------------------------
// dmn_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module dmn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dmn_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output dmn_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import dmn_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wp;
    logic [Q_AW-1:0]     r_rp;
    logic [Q_AW:0]       r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/dmn_back.sv =====
// ----------------------------------------------------------------------------
// dmn_back
// Protocol sequencer: Lamport clock, request state, deferred list and the
// output register that emits messages and the status result.
// ----------------------------------------------------------------------------
module dmn_back #(
    parameter int MAX_NODES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dmn_pkg::ID_W-1:0]       i_node_id,
    input  logic [dmn_pkg::CNT_W-1:0]      i_group,
    input  dmn_pkg::t_cmd                  i_cmd,
    input  logic                           i_q_empty,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dmn_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [2:0] send_dest, [34:3] send_clock,
                                                       // [35] in_section, [36] requesting,
                                                       // [37] all_finished
    output logic [dmn_pkg::OUT_USER_W-1:0] o_m_tuser,  // [1:0] send_type
    output logic                           o_m_tlast
);
    import dmn_pkg::*;

    localparam int SW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int UW = $clog2(MAX_NODES + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REQ,
        PH_CS
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GRANT,
        S_BCAST,
        S_REPLY,
        S_SEND1,
        S_STAT
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    t_phase            r_phase;
    logic [CLK_W-1:0]  r_clock;
    logic [CLK_W-1:0]  r_stamp;
    logic [CNT_W-1:0]  r_reply;
    logic [CNT_W-1:0]  r_fin;
    logic [ID_W-1:0]   r_slot [MAX_NODES];
    logic [UW-1:0]     r_used;
    logic [UW-1:0]     r_ridx;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_sent;
    logic [1:0]        r_bc_type;
    logic              r_grant;

    logic              r_ovalid;
    logic [1:0]        r_otype;
    logic [ID_W-1:0]   r_odest;
    logic [CLK_W-1:0]  r_oclk;
    logic              r_oin_cs;
    logic              r_oreq;
    logic              r_oall;
    logic              r_olast;

    logic              w_free;
    logic [CLK_W-1:0]  w_max;
    logic              w_win;
    logic              w_grant;
    logic              w_dup;
    logic [CNT_W-1:0]  w_rep_inc;
    logic [CNT_W-1:0]  w_nm1;
    logic              w_bc_done;
    logic              w_self;

    assign w_free    = !r_ovalid || i_m_tready;
    assign w_max     = (r_cmd.mclk > r_clock) ? r_cmd.mclk : r_clock;
    assign w_win     = (r_cmd.mclk < r_stamp)
                     || ((r_cmd.mclk == r_stamp) && (r_cmd.src < i_node_id));
    assign w_grant   = (r_phase == PH_IDLE) || ((r_phase == PH_REQ) && w_win);
    assign w_rep_inc = sat_inc4(r_reply);
    assign w_nm1     = i_group - 1'b1;
    assign w_bc_done = (r_sent == w_nm1) || (r_idx == i_group);
    assign w_self    = (r_idx == {1'b0, i_node_id});

    always_comb begin
        w_dup = 1'b0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if ((UW'(i) < r_used) && (r_slot[i] == r_cmd.src)) begin
                w_dup = 1'b1;
            end
        end
    end

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_otype;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {{(OUT_DATA_W-38){1'b0}}, r_oall, r_oreq, r_oin_cs, r_oclk, r_odest};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_IDLE;
            r_clock  <= '0;
            r_stamp  <= '0;
            r_reply  <= '0;
            r_fin    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_idx  <= '0;
                    r_sent <= '0;
                    r_ridx <= '0;
                    unique case (r_cmd.op)
                        OP_LOCAL_REQ: begin
                            if (r_phase == PH_IDLE) begin
                                r_clock   <= sat_inc(r_clock);
                                r_stamp   <= sat_inc(r_clock);
                                r_phase   <= PH_REQ;
                                r_reply   <= '0;
                                r_bc_type <= MSG_REQUEST;
                                r_state   <= S_BCAST;
                            end else begin
                                r_state <= S_STAT;
                            end
                        end
                        OP_LOCAL_REL: begin
                            if (r_phase == PH_CS) begin
                                r_clock <= sat_inc(r_clock);
                                r_state <= S_REPLY;
                            end else begin
                                r_state <= S_STAT;
                            end
                        end
                        OP_LOCAL_FIN: begin
                            r_clock   <= sat_inc(r_clock);
                            r_bc_type <= MSG_FINISH;
                            r_state   <= S_BCAST;
                        end
                        OP_MSG_REQ: begin
                            r_clock <= sat_inc(w_max);
                            r_grant <= w_grant;
                            r_state <= S_GRANT;
                        end
                        OP_MSG_REP: begin
                            r_clock <= sat_inc(w_max);
                            if (r_phase == PH_REQ) begin
                                r_reply <= w_rep_inc;
                                if (w_rep_inc >= w_nm1) begin
                                    r_phase <= PH_CS;
                                end
                            end
                            r_state <= S_STAT;
                        end
                        OP_MSG_FIN: begin
                            r_clock <= sat_inc(w_max);
                            r_fin   <= sat_inc4(r_fin);
                            r_state <= S_STAT;
                        end
                        default: r_state <= S_STAT;
                    endcase
                end
                S_GRANT: begin
                    if (r_grant) begin
                        r_clock <= sat_inc(r_clock);
                        r_state <= S_SEND1;
                    end else begin
                        if (!w_dup && (r_used < w_nm1) && (r_used < UW'(MAX_NODES))) begin
                            r_slot[r_used[SW-1:0]] <= r_cmd.src;
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_STAT;
                    end
                end
                S_BCAST: begin
                    if (w_bc_done) begin
                        // finish is counted after its broadcast goes out
                        if (r_cmd.op == OP_LOCAL_FIN) begin
                            r_fin <= sat_inc4(r_fin);
                        end
                        r_state <= S_STAT;
                    end else if (w_self) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (w_free) begin
                        r_ovalid <= 1'b1;
                        r_otype  <= r_bc_type;
                        r_odest  <= r_idx[ID_W-1:0];
                        r_oclk   <= r_clock;
                        r_oin_cs <= (r_phase == PH_CS);
                        r_oreq   <= (r_phase == PH_REQ);
                        r_oall   <= (r_fin >= i_group);
                        r_olast  <= 1'b0;
                        r_idx    <= r_idx + 1'b1;
                        r_sent   <= r_sent + 1'b1;
                    end
                end
                S_REPLY: begin
                    if (r_ridx == r_used) begin
                        r_used  <= '0;
                        r_phase <= PH_IDLE;
                        r_state <= S_STAT;
                    end else if (w_free) begin
                        r_ovalid <= 1'b1;
                        r_otype  <= MSG_REPLY;
                        r_odest  <= r_slot[r_ridx[SW-1:0]];
                        r_oclk   <= r_clock;
                        r_oin_cs <= (r_phase == PH_CS);
                        r_oreq   <= (r_phase == PH_REQ);
                        r_oall   <= (r_fin >= i_group);
                        r_olast  <= 1'b0;
                        r_ridx   <= r_ridx + 1'b1;
                    end
                end
                S_SEND1: begin
                    if (w_free) begin
                        r_ovalid <= 1'b1;
                        r_otype  <= MSG_REPLY;
                        r_odest  <= r_cmd.src;
                        r_oclk   <= r_clock;
                        r_oin_cs <= (r_phase == PH_CS);
                        r_oreq   <= (r_phase == PH_REQ);
                        r_oall   <= (r_fin >= i_group);
                        r_olast  <= 1'b0;
                        r_state  <= S_STAT;
                    end
                end
                S_STAT: begin
                    if (w_free) begin
                        r_ovalid <= 1'b1;
                        r_otype  <= MSG_NONE;
                        r_odest  <= '0;
                        r_oclk   <= r_clock;
                        r_oin_cs <= (r_phase == PH_CS);
                        r_oreq   <= (r_phase == PH_REQ);
                        r_oall   <= (r_fin >= i_group);
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/distributed_mutex_node.sv =====
// ----------------------------------------------------------------------------
// distributed_mutex_node
// One node of Ricart-Agrawala mutual exclusion with a saturating Lamport clock.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries local commands (request, release, finish) and
//   incoming messages; the master stream carries outgoing messages, each
//   input transaction ending with one status transaction that has tlast set.
//   The cfg channel writes node_id (index 0), node_count (index 1), is always
//   ready; the user must write it only while the node is idle (not enforced).
// Flow:
//   An input transaction is classified in the cycle it is taken and queued
//   (two entries). The sequencer fetches a command, executes it, takes a
//   grant step for an incoming request, then sends one outgoing message per
//   cycle while the master side is not stalled, skips the node's own id in a
//   broadcast, closes a broadcast or a release walk and issues the status; it
//   walks the peers or the deferred list one slot at a time and takes a new
//   transaction only after the status of the last one is issued.
// Reset:
//   Clock, stamps and counters clear, the deferred list empties, node_id
//   returns to 0 and node_count to 2.
// Stall:
//   When i_m_tready is low the master side is stalled, the output register
//   holds its transaction and the sequencer waits; the queue keeps taking
//   input until it fills.
// ----------------------------------------------------------------------------
module distributed_mutex_node #(
    parameter int MAX_NODES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dmn_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [2:0] msg_source, [34:3] msg_clock
    input  logic [dmn_pkg::IN_USER_W-1:0]  i_s_tuser,   // [1:0] kind, [3:2] msg_type
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dmn_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [2:0] send_dest, [34:3] send_clock,
                                                        // [35] in_section, [36] requesting,
                                                        // [37] all_finished
    output logic [dmn_pkg::OUT_USER_W-1:0] o_m_tuser,   // [1:0] send_type
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dmn_pkg::*;

    localparam int GCAP = (MAX_NODES < RESULT_CAP) ? MAX_NODES : RESULT_CAP;

    logic [ID_W-1:0]  r_node_id;
    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] w_group;

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_cmd             w_cmd_in;
    t_cmd             w_cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= '0;
            r_node_count <= CNT_W'(2);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_NODE_ID) begin
                r_node_id <= i_cfg_data[ID_W-1:0];
            end else if (i_cfg_index == CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // effective group size, clamped to 2..min(8, MAX_NODES)
    always_comb begin
        priority if (r_node_count < CNT_W'(2)) begin
            w_group = CNT_W'(2);
        end else if (r_node_count > CNT_W'(GCAP)) begin
            w_group = CNT_W'(GCAP);
        end else begin
            w_group = r_node_count;
        end
    end

    dmn_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_node_id  (r_node_id),
        .i_group    (w_group),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    dmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    dmn_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node_id  (r_node_id),
        .i_group    (w_group),
        .i_cmd      (w_cmd_out),
        .i_q_empty  (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
